// ===== sv/efba_pkg.sv =====
// Shared types, codes and widths for the exact-fit bump allocator.
`timescale 1ns / 1ps
`default_nettype none
package efba_pkg;

  localparam int ENTRIES_DEF = 128;

  localparam int LEN_W   = 24;
  localparam int ADDR_W  = 32;
  localparam int STAT_W  = 3;
  localparam int LIMIT_W = 8;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REUSED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOMEM    = 3'd5;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd6;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BASE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic [ADDR_W-1:0]  BASE_RST   = 32'd0;
  localparam logic [LEN_W-1:0]   LENGTH_RST = 24'hFFFFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 8'd128;

  // one row of the block table
  typedef struct packed {
    logic [LEN_W-1:0] size;
    logic [LEN_W-1:0] offset;
    logic             is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } efba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic hit;
  } efba_sts_t;

endpackage
`default_nettype wire

// ===== sv/efba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module efba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire  [AW-1:0]          waddr,
  input  wire  [WIDTH-1:0]       wdata,
  input  wire                    re,
  input  wire  [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/efba_ctrl.sv =====
// Request sequencer: accept, table scan, commit and output hold.
`timescale 1ns / 1ps
`default_nettype none
module efba_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output efba_pkg::efba_cmd_t      cmd,
  input  wire efba_pkg::efba_sts_t sts
);
  import efba_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // commit only into a free (or draining) output register
        if (!out_vld_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/efba_datapath.sv =====
// Allocator datapath: config registers, table scan, bump state and result register.
`timescale 1ns / 1ps
`default_nettype none
module efba_datapath #(
  parameter int ENTRIES = efba_pkg::ENTRIES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [efba_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [efba_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire                          req_cmd,
  input  wire  [efba_pkg::LEN_W-1:0]   req_length,
  input  wire  [efba_pkg::ADDR_W-1:0]  req_address,
  input  wire efba_pkg::efba_cmd_t     cmd,
  output efba_pkg::efba_sts_t          sts,
  output logic [efba_pkg::STAT_W-1:0]  res_status,
  output logic [efba_pkg::ADDR_W-1:0]  res_address
);
  import efba_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // configuration
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [LEN_W-1:0]   rlen_r, rlen_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  // request
  logic               cmd_r;
  logic [LEN_W-1:0]   len_r;
  logic [ADDR_W-1:0]  target_r;

  // scan
  logic [CW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]      ev_idx_r;
  logic               ev_vld_r, ev_vld_nxt;
  logic               hit_r, hit_nxt;
  logic [AW-1:0]      hit_idx_r;
  entry_t             hit_ent_r;

  // allocator state
  logic [CW-1:0]      count_r, count_nxt;
  logic [LEN_W-1:0]   bump_r, bump_nxt;

  // result
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [ADDR_W-1:0]  baddr_r, baddr_nxt;

  // memory port
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ent;

  logic               zero_alloc, more, hit_now, issue, full, nomem;
  logic [LEN_W:0]     bump_sum;

  efba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    base_nxt  = base_r;
    rlen_nxt  = rlen_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:   base_nxt  = cfg_wdata[ADDR_W-1:0];
        REG_LENGTH: rlen_nxt  = cfg_wdata[LEN_W-1:0];
        REG_LIMIT:  limit_nxt = cfg_wdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  assign ent        = entry_t'(ram_rdata);
  assign zero_alloc = (cmd_r == CMD_ALLOC) && (len_r == '0);
  assign more       = rd_idx_r < count_r;

  always_comb begin
    if (cmd_r == CMD_FREE) begin
      hit_now = cmd.scan && ev_vld_r && ({8'd0, ent.offset} == target_r);
    end else begin
      hit_now = cmd.scan && ev_vld_r && ent.is_free && (ent.size == len_r);
    end
  end

  assign issue    = cmd.scan && !zero_alloc && !hit_now && more;
  assign ram_re   = issue;
  assign sts.done = zero_alloc || hit_now || (!more && !ev_vld_r);
  assign sts.hit  = hit_r;

  assign bump_sum = {1'b0, bump_r} + {1'b0, len_r};
  assign nomem    = bump_sum >= {1'b0, rlen_r};
  assign full     = (32'(count_r) >= 32'(limit_r)) || (32'(count_r) >= 32'(ENTRIES));

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    ev_vld_nxt = 1'b0;
    hit_nxt    = hit_r;
    if (cmd.load) begin
      rd_idx_nxt = '0;
      hit_nxt    = 1'b0;
    end else if (cmd.scan) begin
      ev_vld_nxt = issue;
      if (issue) begin
        rd_idx_nxt = rd_idx_r + CW'(1);
      end
      if (hit_now) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    bump_nxt   = bump_r;
    status_nxt = status_r;
    baddr_nxt  = baddr_r;
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_r;
    ram_wdata  = hit_ent_r;
    if (cmd.commit) begin
      baddr_nxt = '0;
      if (cmd_r == CMD_FREE) begin
        if (hit_r) begin
          ram_we            = 1'b1;
          ram_wdata.is_free = 1'b1;
          status_nxt        = ST_FREED;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end else begin
        priority if (zero_alloc) begin
          status_nxt = ST_ZERO;
        end else if (hit_r) begin
          ram_we            = 1'b1;
          ram_wdata.is_free = 1'b0;
          status_nxt        = ST_REUSED;
          baddr_nxt         = base_r + {8'd0, hit_ent_r.offset};
        end else if (full) begin
          status_nxt = ST_FULL;
        end else if (nomem) begin
          status_nxt = ST_NOMEM;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = count_r[AW-1:0];
          ram_wdata.size    = len_r;
          ram_wdata.offset  = bump_r;
          ram_wdata.is_free = 1'b0;
          status_nxt        = ST_NEW;
          baddr_nxt         = base_r + {8'd0, bump_r};
          count_nxt         = count_r + CW'(1);
          bump_nxt          = bump_sum[LEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RST;
      rlen_r   <= LENGTH_RST;
      limit_r  <= LIMIT_RST;
      rd_idx_r <= '0;
      ev_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      count_r  <= '0;
      bump_r   <= '0;
    end else begin
      base_r   <= base_nxt;
      rlen_r   <= rlen_nxt;
      limit_r  <= limit_nxt;
      rd_idx_r <= rd_idx_nxt;
      ev_vld_r <= ev_vld_nxt;
      hit_r    <= hit_nxt;
      count_r  <= count_nxt;
      bump_r   <= bump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= req_cmd;
      len_r    <= req_length;
      // a free matches when the stored offset equals address minus base
      target_r <= req_address - base_r;
    end
    if (issue) begin
      ev_idx_r <= rd_idx_r[AW-1:0];
    end
    if (hit_now) begin
      hit_idx_r <= ev_idx_r;
      hit_ent_r <= ent;
    end
    status_r <= status_nxt;
    baddr_r  <= baddr_nxt;
  end

  assign res_status  = status_r;
  assign res_address = baddr_r;
endmodule
`default_nettype wire

// ===== sv/exact_fit_bump_allocator_core.sv =====
// Top level of the exact-fit bump allocator: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Exact-fit bump allocator. Each request (allocate a length, or free an address) gives
// exactly one result with a status and, on a successful allocate, the block address
// (region_base plus block offset, modulo 2^32; zero otherwise). The block table lives in
// one RAM of ENTRIES rows and is walked one row per cycle through its single read port,
// stopping at the first hit or at the end of the rows filled so far; a zero-length
// allocate or a request against an empty table reads no row. One request is in work at
// a time; a finished result sits in the output register, so a new request is accepted
// while the previous result still waits, and its commit holds until that register
// drains. The table needs no clearing pass: only rows below the fill count are ever
// read. Write configuration only while no request is in work; a full re-initialization
// is done by reset.
module exact_fit_bump_allocator_core #(
  parameter int ENTRIES = efba_pkg::ENTRIES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // [23:0] length, [55:24] address
  input  wire         in_tuser,   // [0] cmd (0 allocate, 1 free)
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] block_address
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);
  import efba_pkg::*;

  efba_cmd_t cmd;
  efba_sts_t sts;

  // sequencing: accept, scan until first hit or end of filled rows, commit
  efba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // table, bump offset, fill count, config registers and result register
  efba_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_cmd     (in_tuser),
    .req_length  (in_tdata[LEN_W-1:0]),
    .req_address (in_tdata[LEN_W+ADDR_W-1:LEN_W]),
    .cmd         (cmd),
    .sts         (sts),
    .res_status  (out_tuser),
    .res_address (out_tdata)
  );

  // only one phase of the sequencer drives the datapath at a time
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("controller drives more than one datapath phase");

  // a commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before it was taken");

  // a failed or free request reports a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_NEW && out_tuser != ST_REUSED) |-> (out_tdata == '0))
    else $error("nonzero address on a result without an allocation");

  // a finished scan moves to commit right after it ends
  a_scan_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && sts.done) |=> !cmd.scan && !cmd.load)
    else $error("scan continued after it finished");

endmodule
`default_nettype wire
